>>> sv/pvlc_pkg.sv
// Shared types, constants and helper functions of the pack voltage limit calculator.
`timescale 1ns / 1ps

package pvlc_pkg;

  // Field and port widths.
  localparam int unsigned DV_W       = 16;
  localparam int unsigned MV_W       = 16;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Fixed offsets and reset values.
  localparam logic [DV_W-1:0] DESIGN_OFFSET_DV  = 16'd20;
  localparam logic [MV_W-1:0] CELL_MARGIN_MV    = 16'd100;
  localparam logic [DV_W-1:0] CHG_MARGIN_DV     = 16'd8;
  localparam logic [DV_W-1:0] DIS_MARGIN_DV     = 16'd10;
  localparam logic [6:0]      PCT_SCALE         = 7'd100;
  localparam logic [MV_W-1:0] RESET_CELL_MAX_MV = 16'd4200;
  localparam logic [MV_W-1:0] RESET_CELL_MIN_MV = 16'd3000;

  // Mean cell voltage divider: 24 quotient bits, four bits retired per stage.
  localparam int unsigned QUO_W          = 24;
  localparam int unsigned MEAN_W         = 23;
  localparam int unsigned BITS_PER_STAGE = 4;
  localparam int unsigned DIV_STAGES     = QUO_W / BITS_PER_STAGE;

  // Widths of the scaled terms ahead of the divide by 100.
  localparam int unsigned P24_W = 24;
  localparam int unsigned P31_W = 31;
  localparam int unsigned Q24_W = 18;
  localparam int unsigned Q31_W = 25;

  // Reciprocals of 100: ceil(2^31 / 100) and ceil(2^38 / 100).
  localparam logic [24:0] RECIP_24 = 25'd21474837;
  localparam logic [31:0] RECIP_31 = 32'd2748779070;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CELL_COUNT        = 3'd0,
    CFG_CELL_MAX_MV       = 3'd1,
    CFG_CELL_MIN_MV       = 3'd2,
    CFG_DESIGN_MAX_DV     = 3'd3,
    CFG_DESIGN_MIN_DV     = 3'd4,
    CFG_USER_LIMITS_ON    = 3'd5,
    CFG_USER_CHARGE_DV    = 3'd6,
    CFG_USER_DISCHARGE_DV = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [CNT_W-1:0] cell_count;
    logic [MV_W-1:0]  cell_max_mv;
    logic [MV_W-1:0]  cell_min_mv;
    logic [DV_W-1:0]  design_max_dv;
    logic [DV_W-1:0]  design_min_dv;
    logic             user_limits_on;
    logic [DV_W-1:0]  user_charge_dv;
    logic [DV_W-1:0]  user_discharge_dv;
  } cfg_t;

  typedef struct packed {
    logic [MV_W-1:0] high_mv;
    logic [MV_W-1:0] low_mv;
  } cells_t;

  // Word leaving the divider.
  typedef struct packed {
    logic              valid;
    logic [MEAN_W-1:0] mean;
    cells_t            cells;
  } mean_word_t;

  // Word leaving the deviation pipeline: all terms already divided by 100.
  typedef struct packed {
    logic             valid;
    logic [Q24_W-1:0] red_q;
    logic [Q31_W-1:0] inc_q;
    logic             max_neg;
    logic [Q24_W-1:0] max_q;
    logic [Q24_W-1:0] min_q;
  } dev_word_t;

  // Exact floor(x / 100) for a 24-bit x.
  function automatic logic [Q24_W-1:0] div100_24(logic [P24_W-1:0] x);
    logic [48:0] prod;
    prod = 49'(x) * 49'(RECIP_24);
    return prod[48:31];
  endfunction

  // Exact floor(x / 100) for a 31-bit x.
  function automatic logic [Q31_W-1:0] div100_31(logic [P31_W-1:0] x);
    logic [62:0] prod;
    prod = 63'(x) * 63'(RECIP_31);
    return prod[62:38];
  endfunction

endpackage

>>> sv/pack_voltage_limit_calc_core.sv
// Top level of the pack voltage limit calculator: registers, input stage and pipeline.
`timescale 1ns / 1ps

// Usage
// A measurement word (pack voltage in 0.1 V, highest and lowest cell voltage in mV)
// is taken at each rising edge where start is high and busy is low. Busy is never
// raised, so a new word may be presented in every cycle.
// The pair of pack limits for that word appears on charge_limit_dv_o and
// discharge_limit_dv_o with done_o high for exactly one cycle. Words leave in the
// order they entered, one result per word, and the rate is one word per clock.
// The pipeline is the mean cell voltage divider (one input register plus six
// stages of four quotient bits each), then three stages for deviation, scaling by
// the cell count and division by 100, then the output register.
// The receiver cannot stall: each result is shown for one cycle only.
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i) and must
// only be written while no word is in flight. Reset clears the pipeline valid bits
// and loads the register defaults; no result is shown until a word is accepted.

module pack_voltage_limit_calc_core #(
  // Amount by which the design limits are moved inward, in 0.1 V.
  parameter logic [pvlc_pkg::DV_W-1:0] DESIGN_OFFSET_DV = pvlc_pkg::DESIGN_OFFSET_DV
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  input  logic                            start,
  output logic                            busy,
  input  logic [pvlc_pkg::DV_W-1:0]       pack_voltage_dv_i,
  input  logic [pvlc_pkg::MV_W-1:0]       high_cell_mv_i,
  input  logic [pvlc_pkg::MV_W-1:0]       low_cell_mv_i,

  output logic                            done_o,
  output logic [pvlc_pkg::DV_W-1:0]       charge_limit_dv_o,
  output logic [pvlc_pkg::DV_W-1:0]       discharge_limit_dv_o,

  input  logic                            cfg_we_i,
  input  logic [pvlc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pvlc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  pvlc_pkg::cfg_t                cfg_q;
  pvlc_pkg::cfg_t                cfg_d;
  pvlc_pkg::cells_t              cells;
  pvlc_pkg::mean_word_t          mean_word;
  pvlc_pkg::dev_word_t           dev_word;
  logic                          accept;
  logic [pvlc_pkg::QUO_W-1:0]    dividend;

  // The block never holds off a word.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Register file. Writes land directly; an index past the list cannot occur at this width.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (pvlc_pkg::cfg_reg_e'(cfg_idx_i))
        pvlc_pkg::CFG_CELL_COUNT:        cfg_d.cell_count = cfg_wdata_i[pvlc_pkg::CNT_W-1:0];
        pvlc_pkg::CFG_CELL_MAX_MV:       cfg_d.cell_max_mv       = cfg_wdata_i;
        pvlc_pkg::CFG_CELL_MIN_MV:       cfg_d.cell_min_mv       = cfg_wdata_i;
        pvlc_pkg::CFG_DESIGN_MAX_DV:     cfg_d.design_max_dv     = cfg_wdata_i;
        pvlc_pkg::CFG_DESIGN_MIN_DV:     cfg_d.design_min_dv     = cfg_wdata_i;
        pvlc_pkg::CFG_USER_LIMITS_ON:    cfg_d.user_limits_on    = cfg_wdata_i[0];
        pvlc_pkg::CFG_USER_CHARGE_DV:    cfg_d.user_charge_dv    = cfg_wdata_i;
        pvlc_pkg::CFG_USER_DISCHARGE_DV: cfg_d.user_discharge_dv = cfg_wdata_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cell_count        <= '0;
      cfg_q.cell_max_mv       <= pvlc_pkg::RESET_CELL_MAX_MV;
      cfg_q.cell_min_mv       <= pvlc_pkg::RESET_CELL_MIN_MV;
      cfg_q.design_max_dv     <= '0;
      cfg_q.design_min_dv     <= '0;
      cfg_q.user_limits_on    <= 1'b0;
      cfg_q.user_charge_dv    <= '0;
      cfg_q.user_discharge_dv <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Pack voltage times 100 as shifts and adds: 64 + 32 + 4.
  assign dividend = (pvlc_pkg::QUO_W'(pack_voltage_dv_i) << 6) +
                    (pvlc_pkg::QUO_W'(pack_voltage_dv_i) << 5) +
                    (pvlc_pkg::QUO_W'(pack_voltage_dv_i) << 2);

  assign cells.high_mv = high_cell_mv_i;
  assign cells.low_mv  = low_cell_mv_i;

  // Mean cell voltage in mV, pack voltage * 100 / cell count.
  pvlc_div u_div (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cell_count_i  (cfg_q.cell_count),
    .in_valid_i    (accept),
    .in_dividend_i (dividend),
    .in_cells_i    (cells),
    .out_o         (mean_word)
  );

  // Cell deviations and per-cell design limits, scaled to the pack in 0.1 V.
  pvlc_dev u_dev (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .in_i   (mean_word),
    .out_o  (dev_word)
  );

  // Clamp, merge with the static limits and register the result.
  pvlc_lim #(
    .DESIGN_OFFSET_DV (DESIGN_OFFSET_DV)
  ) u_lim (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_i        (dev_word),
    .done_o      (done_o),
    .charge_o    (charge_limit_dv_o),
    .discharge_o (discharge_limit_dv_o)
  );

endmodule

>>> sv/pvlc_div.sv
// Pipelined restoring divider that forms the mean cell voltage from the pack voltage.
`timescale 1ns / 1ps

module pvlc_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [pvlc_pkg::CNT_W-1:0]   cell_count_i,
  input  logic                         in_valid_i,
  input  logic [pvlc_pkg::QUO_W-1:0]   in_dividend_i,
  input  pvlc_pkg::cells_t             in_cells_i,
  output pvlc_pkg::mean_word_t         out_o
);

  typedef struct packed {
    logic [pvlc_pkg::QUO_W-1:0] dvd;
    logic [pvlc_pkg::CNT_W-1:0] rem;
    logic [pvlc_pkg::QUO_W-1:0] quo;
    pvlc_pkg::cells_t           cells;
  } div_data_t;

  // Retires BITS_PER_STAGE quotient bits; the partial remainder stays below the divisor.
  function automatic div_data_t div_step(div_data_t cur, logic [pvlc_pkg::CNT_W-1:0] n);
    div_data_t                nxt;
    logic [pvlc_pkg::CNT_W:0] trial;
    nxt = cur;
    for (int b = 0; b < pvlc_pkg::BITS_PER_STAGE; b++) begin
      trial   = {nxt.rem, nxt.dvd[pvlc_pkg::QUO_W-1]};
      nxt.dvd = {nxt.dvd[pvlc_pkg::QUO_W-2:0], 1'b0};
      if (trial >= {1'b0, n}) begin
        trial   = trial - {1'b0, n};
        nxt.quo = {nxt.quo[pvlc_pkg::QUO_W-2:0], 1'b1};
      end else begin
        nxt.quo = {nxt.quo[pvlc_pkg::QUO_W-2:0], 1'b0};
      end
      nxt.rem = trial[pvlc_pkg::CNT_W-1:0];
    end
    return nxt;
  endfunction

  logic [pvlc_pkg::DIV_STAGES:0] vld_q;
  div_data_t                     dat_q  [pvlc_pkg::DIV_STAGES+1];
  div_data_t                     step_d [pvlc_pkg::DIV_STAGES];

  always_comb begin
    for (int s = 0; s < pvlc_pkg::DIV_STAGES; s++) begin
      step_d[s] = div_step(dat_q[s], cell_count_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[pvlc_pkg::DIV_STAGES-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    dat_q[0].dvd   <= in_dividend_i;
    dat_q[0].rem   <= '0;
    dat_q[0].quo   <= '0;
    dat_q[0].cells <= in_cells_i;
    for (int s = 0; s < pvlc_pkg::DIV_STAGES; s++) begin
      dat_q[s+1] <= step_d[s];
    end
  end

  assign out_o.valid = vld_q[pvlc_pkg::DIV_STAGES];
  assign out_o.mean  = dat_q[pvlc_pkg::DIV_STAGES].quo[pvlc_pkg::MEAN_W-1:0];
  assign out_o.cells = dat_q[pvlc_pkg::DIV_STAGES].cells;

endmodule

>>> sv/pvlc_dev.sv
// Deviation and per-cell limit scaling: subtract, multiply by cell count, divide by 100.
`timescale 1ns / 1ps

module pvlc_dev (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pvlc_pkg::cfg_t             cfg_i,
  input  pvlc_pkg::mean_word_t       in_i,
  output pvlc_pkg::dev_word_t        out_o
);

  // Stage A: positive parts of the cell deviations from the mean.
  logic                          a_valid_q;
  logic [pvlc_pkg::MV_W-1:0]     a_red_q;
  logic [pvlc_pkg::MEAN_W-1:0]   a_inc_q;
  logic [pvlc_pkg::MV_W-1:0]     a_red_d;
  logic [pvlc_pkg::MEAN_W-1:0]   a_inc_d;
  logic [pvlc_pkg::MEAN_W-1:0]   hi_ext;
  logic [pvlc_pkg::MEAN_W-1:0]   lo_ext;
  logic [pvlc_pkg::MEAN_W-1:0]   hi_diff;

  // Stage B: products with the cell count.
  logic                          b_valid_q;
  logic [pvlc_pkg::P24_W-1:0]    b_red_q;
  logic [pvlc_pkg::P31_W-1:0]    b_inc_q;
  logic                          b_max_neg_q;
  logic [pvlc_pkg::P24_W-1:0]    b_max_q;
  logic [pvlc_pkg::P24_W-1:0]    b_min_q;
  logic [pvlc_pkg::MV_W-1:0]     max_mag;
  logic                          max_neg;
  logic [pvlc_pkg::MV_W:0]       min_base;
  logic [pvlc_pkg::MV_W+pvlc_pkg::CNT_W:0] min_prod;

  // Stage C: quotients by 100.
  logic                          c_valid_q;
  logic [pvlc_pkg::Q24_W-1:0]    c_red_q;
  logic [pvlc_pkg::Q31_W-1:0]    c_inc_q;
  logic                          c_max_neg_q;
  logic [pvlc_pkg::Q24_W-1:0]    c_max_q;
  logic [pvlc_pkg::Q24_W-1:0]    c_min_q;

  assign hi_ext  = pvlc_pkg::MEAN_W'(in_i.cells.high_mv);
  assign lo_ext  = pvlc_pkg::MEAN_W'(in_i.cells.low_mv);
  assign hi_diff = hi_ext - in_i.mean;

  always_comb begin
    a_red_d = '0;
    a_inc_d = '0;
    if (hi_ext > in_i.mean) begin
      a_red_d = hi_diff[pvlc_pkg::MV_W-1:0];
    end
    if (in_i.mean > lo_ext) begin
      a_inc_d = in_i.mean - lo_ext;
    end
  end

  // The design cell maximum less the margin may go negative; keep sign and magnitude.
  always_comb begin
    if (cfg_i.cell_max_mv >= pvlc_pkg::CELL_MARGIN_MV) begin
      max_neg = 1'b0;
      max_mag = cfg_i.cell_max_mv - pvlc_pkg::CELL_MARGIN_MV;
    end else begin
      max_neg = 1'b1;
      max_mag = pvlc_pkg::CELL_MARGIN_MV - cfg_i.cell_max_mv;
    end
    min_base = {1'b0, cfg_i.cell_min_mv} + {1'b0, pvlc_pkg::CELL_MARGIN_MV};
    min_prod = (pvlc_pkg::MV_W+pvlc_pkg::CNT_W+1)'(min_base) *
               (pvlc_pkg::MV_W+pvlc_pkg::CNT_W+1)'(cfg_i.cell_count);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      a_valid_q <= in_i.valid;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_red_q     <= a_red_d;
    a_inc_q     <= a_inc_d;

    b_red_q     <= pvlc_pkg::P24_W'(a_red_q) * pvlc_pkg::P24_W'(cfg_i.cell_count);
    b_inc_q     <= pvlc_pkg::P31_W'(a_inc_q) * pvlc_pkg::P31_W'(cfg_i.cell_count);
    b_max_neg_q <= max_neg;
    b_max_q     <= pvlc_pkg::P24_W'(max_mag) * pvlc_pkg::P24_W'(cfg_i.cell_count);
    b_min_q     <= min_prod[pvlc_pkg::P24_W-1:0];

    c_red_q     <= pvlc_pkg::div100_24(b_red_q);
    c_inc_q     <= pvlc_pkg::div100_31(b_inc_q);
    c_max_neg_q <= b_max_neg_q;
    c_max_q     <= pvlc_pkg::div100_24(b_max_q);
    c_min_q     <= pvlc_pkg::div100_24(b_min_q);
  end

  assign out_o.valid   = c_valid_q;
  assign out_o.red_q   = c_red_q;
  assign out_o.inc_q   = c_inc_q;
  assign out_o.max_neg = c_max_neg_q;
  assign out_o.max_q   = c_max_q;
  assign out_o.min_q   = c_min_q;

endmodule

>>> sv/pvlc_lim.sv
// Final limit stage: dynamic limit assembly and clamp, static limits, output registers.
`timescale 1ns / 1ps

module pvlc_lim #(
  parameter logic [pvlc_pkg::DV_W-1:0] DESIGN_OFFSET_DV = pvlc_pkg::DESIGN_OFFSET_DV
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pvlc_pkg::cfg_t             cfg_i,
  input  pvlc_pkg::dev_word_t        in_i,
  output logic                       done_o,
  output logic [pvlc_pkg::DV_W-1:0]  charge_o,
  output logic [pvlc_pkg::DV_W-1:0]  discharge_o
);

  localparam int unsigned SMAX_W = 20;
  localparam int unsigned SMIN_W = pvlc_pkg::Q31_W + 1;

  logic [pvlc_pkg::DV_W-1:0] stat_chg_q;
  logic [pvlc_pkg::DV_W-1:0] stat_dis_q;
  logic [pvlc_pkg::DV_W-1:0] stat_chg_d;
  logic [pvlc_pkg::DV_W-1:0] stat_dis_d;

  logic signed [SMAX_W-1:0]  max_base;
  logic signed [SMAX_W-1:0]  max_lim;
  logic [SMIN_W-1:0]         min_lim;
  logic [pvlc_pkg::DV_W-1:0] dyn_chg;
  logic [pvlc_pkg::DV_W-1:0] dyn_dis;

  logic                      done_q;
  logic [pvlc_pkg::DV_W-1:0] chg_q;
  logic [pvlc_pkg::DV_W-1:0] dis_q;
  logic [pvlc_pkg::DV_W-1:0] chg_d;
  logic [pvlc_pkg::DV_W-1:0] dis_d;

  // Static limits follow the registers; the design offset wraps at 16 bits.
  always_comb begin
    stat_chg_d = cfg_i.design_max_dv - DESIGN_OFFSET_DV;
    stat_dis_d = cfg_i.design_min_dv + DESIGN_OFFSET_DV;
    if (cfg_i.user_limits_on) begin
      if ((cfg_i.user_charge_dv != '0) && (cfg_i.user_charge_dv < stat_chg_d)) begin
        stat_chg_d = cfg_i.user_charge_dv;
      end
      if ((cfg_i.user_discharge_dv != '0) && (cfg_i.user_discharge_dv > stat_dis_d)) begin
        stat_dis_d = cfg_i.user_discharge_dv;
      end
    end
  end

  always_comb begin
    if (in_i.max_neg) begin
      max_base = -$signed(SMAX_W'(in_i.max_q));
    end else begin
      max_base = $signed(SMAX_W'(in_i.max_q));
    end
    max_lim = max_base - $signed(SMAX_W'(in_i.red_q)) -
              $signed(SMAX_W'(pvlc_pkg::CHG_MARGIN_DV));
    min_lim = SMIN_W'(in_i.min_q) + SMIN_W'(in_i.inc_q) + SMIN_W'(pvlc_pkg::DIS_MARGIN_DV);

    if (cfg_i.cell_count == '0) begin
      dyn_chg = '1;
      dyn_dis = '0;
    end else begin
      if (max_lim < 0) begin
        dyn_chg = '0;
      end else if (max_lim > $signed(SMAX_W'({pvlc_pkg::DV_W{1'b1}}))) begin
        dyn_chg = '1;
      end else begin
        dyn_chg = max_lim[pvlc_pkg::DV_W-1:0];
      end
      if (min_lim > SMIN_W'({pvlc_pkg::DV_W{1'b1}})) begin
        dyn_dis = '1;
      end else begin
        dyn_dis = min_lim[pvlc_pkg::DV_W-1:0];
      end
    end

    chg_d = (dyn_chg < stat_chg_q) ? dyn_chg : stat_chg_q;
    dis_d = (dyn_dis > stat_dis_q) ? dyn_dis : stat_dis_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    stat_chg_q <= stat_chg_d;
    stat_dis_q <= stat_dis_d;
    chg_q      <= chg_d;
    dis_q      <= dis_d;
  end

  assign done_o      = done_q;
  assign charge_o    = chg_q;
  assign discharge_o = dis_q;

endmodule
